// File: design/bdp_pkg.sv
// Shared types, widths and counter helpers for the branch direction predictor.
`default_nettype none
package bdp_pkg;

    localparam int PATTERN_ENTRIES_DEF = 512;
    localparam int HISTORY_ENTRIES_DEF = 1024;
    localparam int ADDR_W = 48;
    localparam int HIST_W = 9;
    localparam int C2_W   = 2;
    localparam int C3_W   = 3;
    localparam int NPRED  = 8;
    // global counter plus three selectors share one word
    localparam int GSEL_W = C3_W + 3 * C2_W;

    localparam logic [C2_W-1:0] C2_MAX = 2'b01;
    localparam logic [C2_W-1:0] C2_MIN = 2'b10;
    localparam logic [C3_W-1:0] C3_MAX = 3'b011;
    localparam logic [C3_W-1:0] C3_MIN = 3'b100;

    typedef struct packed {
        logic [C2_W-1:0] bim;
        logic [C2_W-1:0] lctr;
        logic [C3_W-1:0] gctr;
        logic [C3_W-1:0] hctr;
        logic [C2_W-1:0] sel_lg;
        logic [C2_W-1:0] sel_hl;
        logic [C2_W-1:0] sel_hg;
        logic            taken;
        logic            bwd;
    } t_eval_in;

    typedef struct packed {
        logic [NPRED-1:0] pred;
        logic [NPRED-1:0] wrong;
        logic [C2_W-1:0]  bim;
        logic [C2_W-1:0]  lctr;
        logic [C3_W-1:0]  gctr;
        logic [C3_W-1:0]  hctr;
        logic [C2_W-1:0]  sel_lg;
        logic [C2_W-1:0]  sel_hl;
        logic [C2_W-1:0]  sel_hg;
    } t_eval_out;

    function automatic logic [C2_W-1:0] sat2(input logic [C2_W-1:0] v, input logic up);
        logic [C2_W-1:0] r;
        r = v;
        if (up) begin
            if (v != C2_MAX) r = v + 2'd1;
        end else begin
            if (v != C2_MIN) r = v - 2'd1;
        end
        return r;
    endfunction

    function automatic logic [C3_W-1:0] sat3(input logic [C3_W-1:0] v, input logic up);
        logic [C3_W-1:0] r;
        r = v;
        if (up) begin
            if (v != C3_MAX) r = v + 3'd1;
        end else begin
            if (v != C3_MIN) r = v - 3'd1;
        end
        return r;
    endfunction

    // move toward the non-negative side when only the positive predictor was right
    function automatic logic [C2_W-1:0] steer(input logic [C2_W-1:0] v,
                                              input logic pos_ok, input logic neg_ok);
        logic [C2_W-1:0] r;
        r = v;
        if (pos_ok && !neg_ok) begin
            r = sat2(v, 1'b1);
        end else if (!pos_ok && neg_ok) begin
            r = sat2(v, 1'b0);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/bdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bdp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: design/bdp_eval.sv
// Prediction, mispredict mask and counter/selector training for one word.
`default_nettype none
module bdp_eval (
    input  bdp_pkg::t_eval_in  i_in,
    output bdp_pkg::t_eval_out o_out
);
    import bdp_pkg::*;

    logic p_bim, p_loc, p_glb, p_hsh, nn_lg, p_pair, p_maj, p_tour;
    logic ok_loc, ok_glb, ok_hsh;

    always_comb begin
        p_bim  = ~i_in.bim[C2_W-1];
        p_loc  = ~i_in.lctr[C2_W-1];
        p_glb  = ~i_in.gctr[C3_W-1];
        p_hsh  = ~i_in.hctr[C3_W-1];
        nn_lg  = ~i_in.sel_lg[C2_W-1];
        p_pair = nn_lg ? p_loc : p_glb;
        p_maj  = (p_loc & p_glb) | (p_loc & p_hsh) | (p_glb & p_hsh);
        if (nn_lg) p_tour = ~i_in.sel_hl[C2_W-1] ? p_hsh : p_loc;
        else       p_tour = ~i_in.sel_hg[C2_W-1] ? p_hsh : p_glb;
        ok_loc = p_loc == i_in.taken;
        ok_glb = p_glb == i_in.taken;
        ok_hsh = p_hsh == i_in.taken;

        o_out.pred   = {p_tour, p_maj, p_pair, p_hsh, p_glb, p_loc, p_bim, i_in.bwd};
        o_out.wrong  = o_out.pred ^ {NPRED{i_in.taken}};
        o_out.bim    = sat2(i_in.bim, i_in.taken);
        o_out.lctr   = sat2(i_in.lctr, i_in.taken);
        o_out.gctr   = sat3(i_in.gctr, i_in.taken);
        o_out.hctr   = sat3(i_in.hctr, i_in.taken);
        o_out.sel_lg = steer(i_in.sel_lg, ok_loc, ok_glb);
        o_out.sel_hl = steer(i_in.sel_hl, ok_hsh, ok_loc);
        o_out.sel_hg = steer(i_in.sel_hg, ok_hsh, ok_glb);
    end
endmodule
`default_nettype wire

// File: design/multi_scheme_branch_direction_predictor.sv
// Top level: eight-scheme branch direction predictor over five table RAMs.
// A word passes S1, S2 and the output register; the table read-modify-write
// is forwarded. Throughput: one branch word per cycle unless the output stalls.
// Reset: synchronous; afterwards a clearing pass writes zero to every table entry,
// with o_ready held low until it ends.
`default_nettype none
module multi_scheme_branch_direction_predictor #(
    parameter int PATTERN_ENTRIES = bdp_pkg::PATTERN_ENTRIES_DEF,
    parameter int HISTORY_ENTRIES = bdp_pkg::HISTORY_ENTRIES_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire [bdp_pkg::ADDR_W-1:0]  i_branch_address,
    input  wire [bdp_pkg::ADDR_W-1:0]  i_target_address,
    input  wire                        i_outcome_taken,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic                       o_static_pred,
    output logic                       o_bimodal_pred,
    output logic                       o_local_pred,
    output logic                       o_global_pred,
    output logic                       o_hashed_pred,
    output logic                       o_pair_hybrid_pred,
    output logic                       o_majority_pred,
    output logic                       o_tournament_pred,
    output logic [bdp_pkg::NPRED-1:0]  o_wrong_mask,
    output logic                       o_is_backward
);
    import bdp_pkg::*;

    // Tables are indexed by low bits; depths must be powers of two, unchecked.
    localparam int PW   = $clog2(PATTERN_ENTRIES);
    localparam int HW   = $clog2(HISTORY_ENTRIES);
    localparam int MAXD = (PATTERN_ENTRIES > HISTORY_ENTRIES) ? PATTERN_ENTRIES
                                                              : HISTORY_ENTRIES;
    localparam int CW   = $clog2(MAXD);

    // ---------------- handshake and pipeline control ----------------
    // S1: local history read returns and is written back. S2: all counter/selector
    // reads return, predictions form, counters write back. Then the output word.
    logic r_clr_busy;
    logic [CW-1:0] r_clr;
    logic r_s1v, r_s2v;
    logic out_free, s2_adv, s1_adv, acc;

    assign out_free = !o_valid || i_ready;
    assign s2_adv   = r_s2v && out_free;
    assign s1_adv   = r_s1v && (!r_s2v || s2_adv);
    assign o_ready  = !r_clr_busy && (!r_s1v || s1_adv);
    assign acc      = i_valid && o_ready;

    // ---------------- stage 0: index computation ----------------
    logic [HIST_W-1:0] r_ghist;
    logic [PW-1:0] in_bi, in_gi, in_xi;
    logic [HW-1:0] in_hi;

    assign in_bi = i_branch_address[PW-1:0];
    assign in_hi = i_branch_address[HW-1:0];
    assign in_gi = PW'(r_ghist);
    assign in_xi = in_bi ^ PW'(r_ghist);

    // ---------------- stage 1 registers ----------------
    logic [PW-1:0] r_s1_bi, r_s1_gi, r_s1_xi;
    logic [HW-1:0] r_s1_hi;
    logic r_s1_taken, r_s1_bwd;
    logic r_hbyp_hit;
    logic [HIST_W-1:0] r_hbyp_d;
    logic [HIST_W-1:0] hist_rd, s1_hist, s1_hist_new;
    logic [PW-1:0] s1_li;

    assign s1_hist     = r_hbyp_hit ? r_hbyp_d : hist_rd;
    assign s1_hist_new = {s1_hist[HIST_W-2:0], r_s1_taken};
    assign s1_li       = PW'(s1_hist);

    // ---------------- stage 2 registers ----------------
    logic [PW-1:0] r_s2_bi, r_s2_gi, r_s2_xi, r_s2_li;
    logic r_s2_taken, r_s2_bwd;
    logic r_byp_bim_hit, r_byp_lct_hit, r_byp_gsl_hit, r_byp_hct_hit;
    logic [C2_W-1:0] r_byp_bim_d, r_byp_lct_d;
    logic [GSEL_W-1:0] r_byp_gsl_d;
    logic [C3_W-1:0] r_byp_hct_d;
    logic [C2_W-1:0] bim_rd, lct_rd;
    logic [GSEL_W-1:0] gsl_rd, gsl_cur, gsl_new;
    logic [C3_W-1:0] hct_rd;
    t_eval_in  ev_in;
    t_eval_out ev_out;

    assign gsl_cur = r_byp_gsl_hit ? r_byp_gsl_d : gsl_rd;

    always_comb begin
        ev_in.bim    = r_byp_bim_hit ? r_byp_bim_d : bim_rd;
        ev_in.lctr   = r_byp_lct_hit ? r_byp_lct_d : lct_rd;
        ev_in.hctr   = r_byp_hct_hit ? r_byp_hct_d : hct_rd;
        {ev_in.gctr, ev_in.sel_lg, ev_in.sel_hl, ev_in.sel_hg} = gsl_cur;
        ev_in.taken  = r_s2_taken;
        ev_in.bwd    = r_s2_bwd;
    end

    assign gsl_new = {ev_out.gctr, ev_out.sel_lg, ev_out.sel_hl, ev_out.sel_hg};

    bdp_eval u_eval (
        .i_in  (ev_in),
        .o_out (ev_out)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr      <= '0;
            r_ghist    <= '0;
            r_s1v      <= 1'b0;
            r_s2v      <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            // sweep every table address once, then open the input
            if (r_clr_busy) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == CW'(MAXD - 1)) r_clr_busy <= 1'b0;
            end
            // global history advances as soon as the outcome is known
            if (acc) r_ghist <= {r_ghist[HIST_W-2:0], i_outcome_taken};
            if (acc) r_s1v <= 1'b1;
            else if (s1_adv) r_s1v <= 1'b0;
            if (s1_adv) r_s2v <= 1'b1;
            else if (s2_adv) r_s2v <= 1'b0;
            if (s2_adv) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_bi    <= in_bi;
            r_s1_hi    <= in_hi;
            r_s1_gi    <= in_gi;
            r_s1_xi    <= in_xi;
            r_s1_taken <= i_outcome_taken;
            r_s1_bwd   <= i_target_address < i_branch_address;
            // history written by the S1 word at this same edge is missed by the read
            r_hbyp_hit <= s1_adv && (r_s1_hi == in_hi);
            r_hbyp_d   <= s1_hist_new;
        end
        if (s1_adv) begin
            r_s2_bi    <= r_s1_bi;
            r_s2_gi    <= r_s1_gi;
            r_s2_xi    <= r_s1_xi;
            r_s2_li    <= s1_li;
            r_s2_taken <= r_s1_taken;
            r_s2_bwd   <= r_s1_bwd;
            // forward the S2 write-back that lands on the same edge as the read
            r_byp_bim_hit <= s2_adv && (r_s2_bi == r_s1_bi);
            r_byp_lct_hit <= s2_adv && (r_s2_li == s1_li);
            r_byp_gsl_hit <= s2_adv && (r_s2_gi == r_s1_gi);
            r_byp_hct_hit <= s2_adv && (r_s2_xi == r_s1_xi);
            r_byp_bim_d   <= ev_out.bim;
            r_byp_lct_d   <= ev_out.lctr;
            r_byp_gsl_d   <= gsl_new;
            r_byp_hct_d   <= ev_out.hctr;
        end
        if (s2_adv) begin
            o_static_pred      <= ev_out.pred[0];
            o_bimodal_pred     <= ev_out.pred[1];
            o_local_pred       <= ev_out.pred[2];
            o_global_pred      <= ev_out.pred[3];
            o_hashed_pred      <= ev_out.pred[4];
            o_pair_hybrid_pred <= ev_out.pred[5];
            o_majority_pred    <= ev_out.pred[6];
            o_tournament_pred  <= ev_out.pred[7];
            o_wrong_mask       <= ev_out.wrong;
            o_is_backward      <= r_s2_bwd;
        end
    end

    // ---------------- table RAMs ----------------
    // During the clearing pass every write port takes zero at the sweep address.
    logic hist_we, ctr_we;
    logic [HW-1:0] hist_wa;
    logic [HIST_W-1:0] hist_wd;
    logic [PW-1:0] bim_wa, lct_wa, gsl_wa, hct_wa;
    logic [C2_W-1:0] bim_wd, lct_wd;
    logic [GSEL_W-1:0] gsl_wd;
    logic [C3_W-1:0] hct_wd;

    always_comb begin
        hist_we = r_clr_busy || s1_adv;
        ctr_we  = r_clr_busy || s2_adv;
        if (r_clr_busy) begin
            hist_wa = r_clr[HW-1:0];
            hist_wd = '0;
            bim_wa  = r_clr[PW-1:0];
            lct_wa  = r_clr[PW-1:0];
            gsl_wa  = r_clr[PW-1:0];
            hct_wa  = r_clr[PW-1:0];
            bim_wd  = '0;
            lct_wd  = '0;
            gsl_wd  = '0;
            hct_wd  = '0;
        end else begin
            hist_wa = r_s1_hi;
            hist_wd = s1_hist_new;
            bim_wa  = r_s2_bi;
            lct_wa  = r_s2_li;
            gsl_wa  = r_s2_gi;
            hct_wa  = r_s2_xi;
            bim_wd  = ev_out.bim;
            lct_wd  = ev_out.lctr;
            gsl_wd  = gsl_new;
            hct_wd  = ev_out.hctr;
        end
    end

    bdp_ram #(.WIDTH(HIST_W), .DEPTH(HISTORY_ENTRIES)) u_hist_ram (
        .i_clk(i_clk), .i_we(hist_we), .i_waddr(hist_wa), .i_wdata(hist_wd),
        .i_re(acc), .i_raddr(in_hi), .o_rdata(hist_rd)
    );
    bdp_ram #(.WIDTH(C2_W), .DEPTH(PATTERN_ENTRIES)) u_bim_ram (
        .i_clk(i_clk), .i_we(ctr_we), .i_waddr(bim_wa), .i_wdata(bim_wd),
        .i_re(s1_adv), .i_raddr(r_s1_bi), .o_rdata(bim_rd)
    );
    bdp_ram #(.WIDTH(C2_W), .DEPTH(PATTERN_ENTRIES)) u_lct_ram (
        .i_clk(i_clk), .i_we(ctr_we), .i_waddr(lct_wa), .i_wdata(lct_wd),
        .i_re(s1_adv), .i_raddr(s1_li), .o_rdata(lct_rd)
    );
    bdp_ram #(.WIDTH(GSEL_W), .DEPTH(PATTERN_ENTRIES)) u_gsl_ram (
        .i_clk(i_clk), .i_we(ctr_we), .i_waddr(gsl_wa), .i_wdata(gsl_wd),
        .i_re(s1_adv), .i_raddr(r_s1_gi), .o_rdata(gsl_rd)
    );
    bdp_ram #(.WIDTH(C3_W), .DEPTH(PATTERN_ENTRIES)) u_hct_ram (
        .i_clk(i_clk), .i_we(ctr_we), .i_waddr(hct_wa), .i_wdata(hct_wd),
        .i_re(s1_adv), .i_raddr(r_s1_xi), .o_rdata(hct_rd)
    );

    // ---------------- assertions ----------------
    a_clr_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1v && !r_s2v && !o_valid)
        else $error("pipeline active during clearing pass");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2v && !out_free) |=> r_s2v && $stable(r_s2_gi))
        else $error("stalled S2 word lost");

    a_static_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_static_pred == o_is_backward) &&
                    (o_wrong_mask[0] != o_wrong_mask[1] ||
                     o_static_pred == o_bimodal_pred))
        else $error("mispredict mask inconsistent with predictions");

endmodule
`default_nettype wire

// File: tb/multi_scheme_branch_direction_predictor_test.sv
// Self-checking testbench for the multi-scheme branch direction predictor.
`timescale 1ns / 1ps
module multi_scheme_branch_direction_predictor_test;
    import bdp_pkg::*;

    localparam int PAT_N   = 512;
    localparam int HIST_N  = 1024;
    localparam int RANDOM_WORDS = 700;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] tgt;
        logic              taken;
    } t_branch;

    typedef struct packed {
        logic [NPRED-1:0] pred;   // bit 0 static .. bit 7 tournament
        logic [NPRED-1:0] wrong;
        logic             bwd;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic [ADDR_W-1:0] i_branch_address = '0;
    logic [ADDR_W-1:0] i_target_address = '0;
    logic i_outcome_taken = 1'b0;
    logic o_ready, o_valid;
    logic o_static_pred, o_bimodal_pred, o_local_pred, o_global_pred;
    logic o_hashed_pred, o_pair_hybrid_pred, o_majority_pred, o_tournament_pred;
    logic [NPRED-1:0] o_wrong_mask;
    logic o_is_backward;

    multi_scheme_branch_direction_predictor uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_branch_address(i_branch_address), .i_target_address(i_target_address),
        .i_outcome_taken(i_outcome_taken),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_static_pred(o_static_pred), .o_bimodal_pred(o_bimodal_pred),
        .o_local_pred(o_local_pred), .o_global_pred(o_global_pred),
        .o_hashed_pred(o_hashed_pred), .o_pair_hybrid_pred(o_pair_hybrid_pred),
        .o_majority_pred(o_majority_pred), .o_tournament_pred(o_tournament_pred),
        .o_wrong_mask(o_wrong_mask), .o_is_backward(o_is_backward)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow predictor state; counters hold signed two's complement values.
    logic signed [1:0] bim_ctr  [PAT_N];
    logic [HIST_W-1:0] loc_hist [HIST_N];
    logic signed [1:0] loc_ctr  [PAT_N];
    logic [HIST_W-1:0] glb_hist;
    logic signed [2:0] glb_ctr  [PAT_N];
    logic signed [2:0] gsh_ctr  [PAT_N];
    logic signed [1:0] lg_sel   [PAT_N];
    logic signed [1:0] hl_sel   [PAT_N];
    logic signed [1:0] hg_sel   [PAT_N];

    t_branch  pending_branches[$];
    t_verdict expected_verdicts[$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       stimulus_done = 1'b0;

    function automatic logic signed [1:0] bump2(logic signed [1:0] v, logic up);
        if (up) return (v < 2'sd1) ? v + 2'sd1 : v;
        return (v > -2'sd2) ? v - 2'sd1 : v;
    endfunction

    function automatic logic signed [2:0] bump3(logic signed [2:0] v, logic up);
        if (up) return (v < 3'sd3) ? v + 3'sd1 : v;
        return (v > -3'sd4) ? v - 3'sd1 : v;
    endfunction

    function automatic logic signed [1:0] lean(logic signed [1:0] v, logic pos_ok,
                                               logic neg_ok);
        if (pos_ok && !neg_ok) return bump2(v, 1'b1);
        if (!pos_ok && neg_ok) return bump2(v, 1'b0);
        return v;
    endfunction

    // Form all predictions from the current state, then train it with the outcome.
    function automatic t_verdict predict_and_train(t_branch b);
        t_verdict v;
        int bi, hi, li, gi, xi;
        logic pl, pg, ph, tk;
        tk = b.taken;
        bi = b.pc % PAT_N;
        hi = b.pc % HIST_N;
        li = loc_hist[hi] % PAT_N;
        gi = glb_hist % PAT_N;
        xi = (bi ^ glb_hist) % PAT_N;
        pl = loc_ctr[li] >= 0;
        pg = glb_ctr[gi] >= 0;
        ph = gsh_ctr[xi] >= 0;
        v.pred[0] = b.tgt < b.pc;
        v.pred[1] = bim_ctr[bi] >= 0;
        v.pred[2] = pl;
        v.pred[3] = pg;
        v.pred[4] = ph;
        v.pred[5] = (lg_sel[gi] >= 0) ? pl : pg;
        v.pred[6] = (pl + pg + ph) >= 2;
        if (lg_sel[gi] >= 0) v.pred[7] = (hl_sel[gi] >= 0) ? ph : pl;
        else                 v.pred[7] = (hg_sel[gi] >= 0) ? ph : pg;
        v.wrong = v.pred ^ {NPRED{tk}};
        v.bwd = v.pred[0];
        bim_ctr[bi] = bump2(bim_ctr[bi], tk);
        loc_ctr[li] = bump2(loc_ctr[li], tk);
        glb_ctr[gi] = bump3(glb_ctr[gi], tk);
        gsh_ctr[xi] = bump3(gsh_ctr[xi], tk);
        lg_sel[gi] = lean(lg_sel[gi], pl == tk, pg == tk);
        hl_sel[gi] = lean(hl_sel[gi], ph == tk, pl == tk);
        hg_sel[gi] = lean(hg_sel[gi], ph == tk, pg == tk);
        loc_hist[hi] = {loc_hist[hi][HIST_W-2:0], tk};
        glb_hist = {glb_hist[HIST_W-2:0], tk};
        return v;
    endfunction

    // Mostly short gaps, now and then a long one, sometimes none for a while.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    // Driver: hold each word until accepted, then advance after a random gap.
    int drive_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_verdicts.push_back(predict_and_train(
                    t_branch'{i_branch_address, i_target_address, i_outcome_taken}));
            end
            if (!i_valid || o_ready) begin
                if (drive_gap > 0 || pending_branches.size() == 0) begin
                    i_valid <= 1'b0;
                    if (drive_gap > 0) drive_gap <= drive_gap - 1;
                end else begin
                    t_branch b;
                    b = pending_branches.pop_front();
                    i_valid <= 1'b1;
                    i_branch_address <= b.pc;
                    i_target_address <= b.tgt;
                    i_outcome_taken <= b.taken;
                    drive_gap <= gap_len();
                end
            end
        end
    end

    // Monitor: check each accepted result word against the oldest prediction.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                t_verdict got, want;
                got.pred = {o_tournament_pred, o_majority_pred, o_pair_hybrid_pred,
                            o_hashed_pred, o_global_pred,
                            o_local_pred, o_bimodal_pred, o_static_pred};
                got.wrong = o_wrong_mask;
                got.bwd = o_is_backward;
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result word %h", got);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: pred exp %b got %b, ",
                                      "wrong exp %b got %b, bwd exp %b got %b"},
                                     want.pred, got.pred, want.wrong, got.wrong,
                                     want.bwd, got.bwd);
                    end
                end
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                i_ready <= 1'b1;
                stall_left <= gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_branch(logic [ADDR_W-1:0] pc, logic [ADDR_W-1:0] tgt, logic tk);
        pending_branches.push_back(t_branch'{pc, tgt, tk});
    endtask

    initial begin
        logic [ADDR_W-1:0] loop_pc [8];
        int kind, pick;
        logic [ADDR_W-1:0] pc;
        for (int i = 0; i < PAT_N; i++) begin
            bim_ctr[i] = 0; loc_ctr[i] = 0; glb_ctr[i] = 0; gsh_ctr[i] = 0;
            lg_sel[i] = 0; hl_sel[i] = 0; hg_sel[i] = 0;
        end
        for (int i = 0; i < HIST_N; i++) loc_hist[i] = '0;
        glb_hist = '0;

        // Directed: address extremes, equal addresses, backward and forward,
        // and runs of one outcome to drive the counters toward saturation.
        queue_branch('0, '0, 1'b1);
        queue_branch('1, '1, 1'b0);
        queue_branch('1, '0, 1'b1);
        queue_branch('0, '1, 1'b0);
        queue_branch(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 1'b1);
        for (int i = 0; i < 10; i++) queue_branch(48'h1234, 48'h1000, 1'b1);
        for (int i = 0; i < 10; i++) queue_branch(48'h1234, 48'h1000, 1'b0);

        // Random: mostly loops over a few hot branches with biased, periodic or
        // random outcomes, plus fully random noise words.
        for (int i = 0; i < 8; i++) loop_pc[i] = rand_addr();
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                pick = $urandom_range(0, 7);
                pc = loop_pc[pick];
                queue_branch(pc, (pick < 4) ? pc - $urandom_range(1, 64)
                                            : pc + $urandom_range(0, 64),
                             (pick % 3 == 0) ? ($urandom_range(0, 7) != 0)
                                             : (pick % 3 == 1) ? (n % 3 != 2)
                                                               : 1'($urandom_range(0, 1)));
            end else begin
                queue_branch(rand_addr(), rand_addr(), 1'($urandom_range(0, 1)));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_branches.size() == 0 && !i_valid);
        wait (expected_verdicts.size() == 0);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: filelist.f
design/bdp_pkg.sv
design/bdp_ram.sv
design/bdp_eval.sv
design/multi_scheme_branch_direction_predictor.sv
tb/multi_scheme_branch_direction_predictor_test.sv
